// ===== rtl/bsr_pkg.sv =====
// Shared widths, codes and the decoded command type for the byte stack.
package bsr_pkg;

	localparam int CMD_W = 3;
	localparam int VAL_W = 8;
	localparam int CNT_W = 7;
	localparam int STS_W = 2;
	localparam int CAP_W = 7;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DUP    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_ROT_UP = 3'd4;
	localparam logic [CMD_W-1:0] CMD_ROT_DN = 3'd5;
	localparam logic [CMD_W-1:0] CMD_PRINT  = 3'd6;

	localparam logic [STS_W-1:0] STS_OK      = 2'd0;
	localparam logic [STS_W-1:0] STS_EMPTY   = 2'd1;
	localparam logic [STS_W-1:0] STS_FULL    = 2'd2;
	localparam logic [STS_W-1:0] STS_BAD_CNT = 2'd3;

	typedef enum logic [2:0] {
		OP_PUSH,
		OP_POP,
		OP_PEEK,
		OP_DUP,
		OP_ROT_UP,
		OP_ROT_DN,
		OP_PRINT
	} op_kind_t;

	typedef struct packed {
		op_kind_t         kind;
		logic [VAL_W-1:0] value;
		logic [CNT_W-1:0] count;
	} op_t;

endpackage

// ===== rtl/bsr_if.sv =====
// Command and result channel interfaces of the byte stack.
interface bsr_req_if;
	logic                       valid;
	logic                       ready;
	logic [bsr_pkg::CMD_W-1:0]  cmd;
	logic [bsr_pkg::VAL_W-1:0]  value;
	logic [bsr_pkg::CNT_W-1:0]  count;

	modport source(output valid, output cmd, output value, output count, input ready);
	modport sink(input valid, input cmd, input value, input count, output ready);
endinterface

interface bsr_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [bsr_pkg::STS_W-1:0]  status;
	logic                       has_byte;
	logic [bsr_pkg::VAL_W-1:0]  data_byte;
	logic                       last;

	modport source(output valid, output status, output has_byte, output data_byte,
		output last, input ready);
	modport sink(input valid, input status, input has_byte, input data_byte,
		input last, output ready);
endinterface

// ===== rtl/bsr_front.sv =====
// Front end: takes command words, decodes them and queues them for the back end.
module bsr_front (
	input  logic             clk,
	input  logic             arst_n,
	bsr_req_if.sink          req,
	output logic             op_valid,
	output bsr_pkg::op_t     op,
	input  logic             op_take
);

	bsr_pkg::op_t q_q [2];
	logic [1:0]   cnt_q;
	logic         wp_q;
	logic         rp_q;

	bsr_pkg::op_t dec;
	logic         known;
	logic         enq;

	always_comb begin
		known       = 1'b1;
		dec.kind    = bsr_pkg::OP_PUSH;
		dec.value   = req.value;
		dec.count   = req.count;
		case (req.cmd)
			bsr_pkg::CMD_PUSH:   dec.kind = bsr_pkg::OP_PUSH;
			bsr_pkg::CMD_POP:    dec.kind = bsr_pkg::OP_POP;
			bsr_pkg::CMD_PEEK:   dec.kind = bsr_pkg::OP_PEEK;
			bsr_pkg::CMD_DUP:    dec.kind = bsr_pkg::OP_DUP;
			bsr_pkg::CMD_ROT_UP: dec.kind = bsr_pkg::OP_ROT_UP;
			bsr_pkg::CMD_ROT_DN: dec.kind = bsr_pkg::OP_ROT_DN;
			bsr_pkg::CMD_PRINT:  dec.kind = bsr_pkg::OP_PRINT;
			default:             known    = 1'b0;
		endcase
	end

	// unknown commands are taken and dropped
	assign req.ready = (cnt_q != 2'd2);
	assign enq       = req.valid && req.ready && known;
	assign op_valid  = (cnt_q != 2'd0);
	assign op        = q_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
		end else begin
			if (enq)
				wp_q <= ~wp_q;
			if (op_take)
				rp_q <= ~rp_q;
			if (enq && !op_take)
				cnt_q <= cnt_q + 2'd1;
			else if (!enq && op_take)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (enq)
			q_q[wp_q] <= dec;
	end

endmodule

// ===== rtl/bsr_back.sv =====
// Back end: runs queued commands against the byte store and drives the result channel.
module bsr_back #(
	parameter int DEPTH = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [bsr_pkg::CAP_W-1:0]  cfg_wdata,
	input  logic                       op_valid,
	input  bsr_pkg::op_t               op,
	output logic                       op_take,
	bsr_rsp_if.source                  rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int FW = $clog2(DEPTH + 1);
	localparam int LW = (FW > bsr_pkg::CNT_W) ? FW : bsr_pkg::CNT_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEND,
		ST_SWEEP,
		ST_ROT_END,
		ST_DUP_WR
	} st_t;

	logic [bsr_pkg::VAL_W-1:0] store_q [DEPTH];
	logic [bsr_pkg::VAL_W-1:0] rdata_q;

	st_t                       state_q, state_d;
	logic [bsr_pkg::CAP_W-1:0] cap_q, cap_d;
	logic [FW-1:0]             fill_q, fill_d;
	logic [AW-1:0]             rd_ptr_q, rd_ptr_d;
	logic [AW-1:0]             pa_q, pa_d;
	logic [FW-1:0]             rem_q, rem_d;
	logic                      dv_q, dv_d;
	logic                      dl_q, dl_d;
	logic                      first_q, first_d;
	logic                      up_q, up_d;
	logic [bsr_pkg::VAL_W-1:0] tmp_q, tmp_d;

	logic                      ovalid_q, ovalid_d;
	logic [bsr_pkg::STS_W-1:0] ostatus_q, ostatus_d;
	logic                      ohas_q, ohas_d;
	logic [bsr_pkg::VAL_W-1:0] odata_q, odata_d;
	logic                      olast_q, olast_d;

	logic                      mem_re, mem_we;
	logic [AW-1:0]             mem_raddr, mem_waddr;
	logic [bsr_pkg::VAL_W-1:0] mem_wdata;

	logic                      emit;
	logic [bsr_pkg::STS_W-1:0] e_status;
	logic                      e_has;
	logic [bsr_pkg::VAL_W-1:0] e_data;
	logic                      e_last;

	logic                      out_free;
	logic [LW-1:0]             fill_ext, n_ext;
	logic                      full, empty, rot_bad;
	logic [AW-1:0]             top_addr, base_addr, start_addr;

	assign out_free  = !ovalid_q || rsp.ready;
	assign fill_ext  = LW'(fill_q);
	assign n_ext     = LW'(op.count);
	assign full      = (fill_ext >= LW'(cap_q)) || (fill_q == FW'(DEPTH));
	assign empty     = (fill_q == '0);
	assign rot_bad   = (op.count == '0) || (n_ext > fill_ext);
	assign top_addr  = AW'(fill_q - FW'(1));
	assign base_addr = AW'(fill_ext - n_ext);
	assign start_addr = (op.kind == bsr_pkg::OP_ROT_UP) ? top_addr : base_addr;

	always_comb begin
		state_d   = state_q;
		cap_d     = cfg_we ? cfg_wdata : cap_q;
		fill_d    = fill_q;
		rd_ptr_d  = rd_ptr_q;
		pa_d      = pa_q;
		rem_d     = rem_q;
		dv_d      = dv_q;
		dl_d      = dl_q;
		first_d   = first_q;
		up_d      = up_q;
		tmp_d     = tmp_q;
		op_take   = 1'b0;
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		mem_raddr = rd_ptr_q;
		mem_waddr = pa_q;
		mem_wdata = rdata_q;
		emit      = 1'b0;
		e_status  = bsr_pkg::STS_OK;
		e_has     = 1'b0;
		e_data    = '0;
		e_last    = 1'b1;

		case (state_q)
			ST_IDLE: begin
				if (op_valid) begin
					case (op.kind)
						bsr_pkg::OP_PUSH: begin
							if (out_free) begin
								op_take = 1'b1;
								emit    = 1'b1;
								if (full) begin
									e_status = bsr_pkg::STS_FULL;
								end else begin
									mem_we    = 1'b1;
									mem_waddr = AW'(fill_q);
									mem_wdata = op.value;
									fill_d    = fill_q + FW'(1);
								end
							end
						end
						bsr_pkg::OP_POP, bsr_pkg::OP_PEEK, bsr_pkg::OP_PRINT: begin
							if (empty) begin
								if (out_free) begin
									op_take = 1'b1;
									emit    = 1'b1;
									if (op.kind != bsr_pkg::OP_PRINT)
										e_status = bsr_pkg::STS_EMPTY;
								end
							end else begin
								op_take  = 1'b1;
								rd_ptr_d = top_addr;
								rem_d    = (op.kind == bsr_pkg::OP_PRINT) ? fill_q : FW'(1);
								dv_d     = 1'b0;
								state_d  = ST_SEND;
								if (op.kind == bsr_pkg::OP_POP)
									fill_d = fill_q - FW'(1);
							end
						end
						bsr_pkg::OP_DUP: begin
							if (full || empty) begin
								if (out_free) begin
									op_take  = 1'b1;
									emit     = 1'b1;
									e_status = full ? bsr_pkg::STS_FULL : bsr_pkg::STS_EMPTY;
								end
							end else begin
								op_take   = 1'b1;
								mem_re    = 1'b1;
								mem_raddr = top_addr;
								state_d   = ST_DUP_WR;
							end
						end
						bsr_pkg::OP_ROT_UP, bsr_pkg::OP_ROT_DN: begin
							if (rot_bad) begin
								if (out_free) begin
									op_take  = 1'b1;
									emit     = 1'b1;
									e_status = bsr_pkg::STS_BAD_CNT;
								end
							end else begin
								op_take   = 1'b1;
								mem_re    = 1'b1;
								mem_raddr = start_addr;
								pa_d      = start_addr;
								up_d      = (op.kind == bsr_pkg::OP_ROT_UP);
								rd_ptr_d  = (op.kind == bsr_pkg::OP_ROT_UP) ?
									start_addr - AW'(1) : start_addr + AW'(1);
								rem_d     = FW'(n_ext - LW'(1));
								first_d   = 1'b1;
								state_d   = ST_SWEEP;
							end
						end
						default: ;
					endcase
				end
			end
			ST_SEND: begin
				if (dv_q && out_free) begin
					emit   = 1'b1;
					e_has  = 1'b1;
					e_data = rdata_q;
					e_last = dl_q;
					dv_d   = 1'b0;
					if (dl_q)
						state_d = ST_IDLE;
				end
				if (rem_q != '0 && (!dv_q || out_free)) begin
					mem_re    = 1'b1;
					mem_raddr = rd_ptr_q;
					rd_ptr_d  = rd_ptr_q - AW'(1);
					rem_d     = rem_q - FW'(1);
					dv_d      = 1'b1;
					dl_d      = (rem_q == FW'(1));
				end
			end
			ST_SWEEP: begin
				// each word read moves one place towards the vacated end
				if (first_q) begin
					tmp_d   = rdata_q;
					first_d = 1'b0;
				end else begin
					mem_we    = 1'b1;
					mem_waddr = up_q ? pa_q + AW'(1) : pa_q - AW'(1);
					mem_wdata = rdata_q;
				end
				if (rem_q != '0) begin
					mem_re    = 1'b1;
					mem_raddr = rd_ptr_q;
					pa_d      = rd_ptr_q;
					rd_ptr_d  = up_q ? rd_ptr_q - AW'(1) : rd_ptr_q + AW'(1);
					rem_d     = rem_q - FW'(1);
				end else begin
					state_d = ST_ROT_END;
				end
			end
			ST_ROT_END: begin
				if (out_free) begin
					mem_we    = 1'b1;
					mem_waddr = pa_q;
					mem_wdata = tmp_q;
					emit      = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			ST_DUP_WR: begin
				if (out_free) begin
					mem_we    = 1'b1;
					mem_waddr = AW'(fill_q);
					mem_wdata = rdata_q;
					fill_d    = fill_q + FW'(1);
					emit      = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase

		ovalid_d  = emit ? 1'b1 : (rsp.ready ? 1'b0 : ovalid_q);
		ostatus_d = emit ? e_status : ostatus_q;
		ohas_d    = emit ? e_has : ohas_q;
		odata_d   = emit ? e_data : odata_q;
		olast_d   = emit ? e_last : olast_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cap_q     <= bsr_pkg::CAP_RESET;
			fill_q    <= '0;
			rd_ptr_q  <= '0;
			pa_q      <= '0;
			rem_q     <= '0;
			dv_q      <= 1'b0;
			dl_q      <= 1'b0;
			first_q   <= 1'b0;
			up_q      <= 1'b0;
			tmp_q     <= '0;
			ovalid_q  <= 1'b0;
			ostatus_q <= bsr_pkg::STS_OK;
			ohas_q    <= 1'b0;
			odata_q   <= '0;
			olast_q   <= 1'b0;
		end else begin
			state_q   <= state_d;
			cap_q     <= cap_d;
			fill_q    <= fill_d;
			rd_ptr_q  <= rd_ptr_d;
			pa_q      <= pa_d;
			rem_q     <= rem_d;
			dv_q      <= dv_d;
			dl_q      <= dl_d;
			first_q   <= first_d;
			up_q      <= up_d;
			tmp_q     <= tmp_d;
			ovalid_q  <= ovalid_d;
			ostatus_q <= ostatus_d;
			ohas_q    <= ohas_d;
			odata_q   <= odata_d;
			olast_q   <= olast_d;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			store_q[mem_waddr] <= mem_wdata;
		if (mem_re)
			rdata_q <= store_q[mem_raddr];
	end

	assign rsp.valid     = ovalid_q;
	assign rsp.status    = ostatus_q;
	assign rsp.has_byte  = ohas_q;
	assign rsp.data_byte = odata_q;
	assign rsp.last      = olast_q;

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(DEPTH))
		else $error("fill count beyond store depth");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we && mem_re |-> mem_waddr != mem_raddr)
		else $error("store read and write hit one address");

	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		op_take |-> op_valid)
		else $error("command taken from empty queue");

	a_send_pending: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SEND && !dv_q |-> rem_q != '0)
		else $error("send stalled with nothing to read");

endmodule

// ===== rtl/byte_stack_with_rotate_core.sv =====
// Top level of the byte stack with dup and rotate.
// Commands pass through a two-word queue to an executor that owns a single-port-read,
// single-port-write byte store of DEPTH words; capacity (reset 64) caps the fill.
// In the executor, push, errors and an empty print answer directly; dup, pop and peek
// read the top word; a rotate reads its n words in turn, shifts each one place and
// writes the first last; print sends one result word per cycle after the first unless
// the result side stalls. The store gives one read per cycle, which paces rotates and
// print. Results leave through an output register; a stalled result side holds the
// executor, and the queue takes up to two more words before the intake stalls.
module byte_stack_with_rotate_core #(
	parameter int DEPTH = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [bsr_pkg::CAP_W-1:0]  cfg_wdata,
	bsr_req_if.sink                    req,
	bsr_rsp_if.source                  rsp
);

	logic         op_valid;
	bsr_pkg::op_t op;
	logic         op_take;

	bsr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.op_valid (op_valid),
		.op       (op),
		.op_take  (op_take)
	);

	bsr_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.op_valid  (op_valid),
		.op        (op),
		.op_take   (op_take),
		.rsp       (rsp)
	);

endmodule

// ===== bench/byte_stack_with_rotate_core_tb.sv =====
// Self-checking testbench for byte_stack_with_rotate_core: directed corners, then random traffic.
`timescale 1ns / 100ps
module byte_stack_with_rotate_core_tb;

	localparam int DEPTH = 64;
	localparam int HOLD_CYCLES = 400;
	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE_CYCLES = DEPTH + 8;

	typedef enum int {CHURN, SHRINK, GROW} mix_t;

	typedef logic [bsr_pkg::VAL_W-1:0] val_t;
	typedef logic [bsr_pkg::CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic [bsr_pkg::STS_W-1:0] status;
		logic                      has_byte;
		logic [bsr_pkg::VAL_W-1:0] data_byte;
		logic                      last;
	} rsp_word_t;

	class stack_tracker;
		logic [bsr_pkg::VAL_W-1:0] bytes [DEPTH];
		int fill;
		int limit;
		int errors;
		rsp_word_t pending_results[$];

		function new();
			fill = 0;
			limit = DEPTH;
			errors = 0;
		endfunction

		function void set_capacity(logic [bsr_pkg::CAP_W-1:0] c);
			limit = (int'(c) < DEPTH) ? int'(c) : DEPTH;
		endfunction

		function void queue_word(logic [bsr_pkg::STS_W-1:0] s, logic h,
			logic [bsr_pkg::VAL_W-1:0] d, logic l);
			rsp_word_t w;
			w.status = s;
			w.has_byte = h;
			w.data_byte = d;
			w.last = l;
			pending_results.push_back(w);
		endfunction

		function void note_command(bsr_pkg::op_t w);
			int n;
			int i;
			logic [bsr_pkg::VAL_W-1:0] tmp;
			n = int'(w.count);
			case (w.kind)
				bsr_pkg::OP_PUSH: begin
					if (fill >= limit) begin
						queue_word(bsr_pkg::STS_FULL, 1'b0, '0, 1'b1);
					end else begin
						bytes[fill] = w.value;
						fill++;
						queue_word(bsr_pkg::STS_OK, 1'b0, '0, 1'b1);
					end
				end
				bsr_pkg::OP_POP: begin
					if (fill == 0) begin
						queue_word(bsr_pkg::STS_EMPTY, 1'b0, '0, 1'b1);
					end else begin
						fill--;
						queue_word(bsr_pkg::STS_OK, 1'b1, bytes[fill], 1'b1);
					end
				end
				bsr_pkg::OP_PEEK: begin
					if (fill == 0) queue_word(bsr_pkg::STS_EMPTY, 1'b0, '0, 1'b1);
					else queue_word(bsr_pkg::STS_OK, 1'b1, bytes[fill-1], 1'b1);
				end
				bsr_pkg::OP_DUP: begin
					if (fill >= limit) begin
						queue_word(bsr_pkg::STS_FULL, 1'b0, '0, 1'b1);
					end else if (fill == 0) begin
						queue_word(bsr_pkg::STS_EMPTY, 1'b0, '0, 1'b1);
					end else begin
						bytes[fill] = bytes[fill-1];
						fill++;
						queue_word(bsr_pkg::STS_OK, 1'b0, '0, 1'b1);
					end
				end
				bsr_pkg::OP_ROT_UP, bsr_pkg::OP_ROT_DN: begin
					if (n == 0 || n > fill) begin
						queue_word(bsr_pkg::STS_BAD_CNT, 1'b0, '0, 1'b1);
					end else if (w.kind == bsr_pkg::OP_ROT_UP) begin
						tmp = bytes[fill-1];
						for (i = fill - 1; i > fill - n; i--) bytes[i] = bytes[i-1];
						bytes[fill-n] = tmp;
						queue_word(bsr_pkg::STS_OK, 1'b0, '0, 1'b1);
					end else begin
						tmp = bytes[fill-n];
						for (i = fill - n; i + 1 < fill; i++) bytes[i] = bytes[i+1];
						bytes[fill-1] = tmp;
						queue_word(bsr_pkg::STS_OK, 1'b0, '0, 1'b1);
					end
				end
				bsr_pkg::OP_PRINT: begin
					if (fill == 0) begin
						queue_word(bsr_pkg::STS_OK, 1'b0, '0, 1'b1);
					end else begin
						for (i = 0; i < fill; i++)
							queue_word(bsr_pkg::STS_OK, 1'b1, bytes[fill-1-i], i + 1 == fill);
					end
				end
				default: ;
			endcase
		endfunction

		function bit field_ok(string name, int want, int got);
			if (want != got)
				$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			return want == got;
		endfunction

		function void check_result(rsp_word_t got);
			rsp_word_t want;
			bit ok;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected word, expected none got %h", $time, got);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			ok = field_ok("status", int'(want.status), int'(got.status));
			ok = field_ok("has_byte", int'(want.has_byte), int'(got.has_byte)) && ok;
			ok = field_ok("data_byte", int'(want.data_byte), int'(got.data_byte)) && ok;
			ok = field_ok("last", int'(want.last), int'(got.last)) && ok;
			if (!ok) errors++;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [bsr_pkg::CAP_W-1:0] cfg_wdata;
	bit snd_idle;
	bit rcv_idle;
	bit hold_req;

	bsr_req_if req();
	bsr_rsp_if rsp();

	stack_tracker tracker = new();

	byte_stack_with_rotate_core #(.DEPTH(DEPTH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req(req),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [bsr_pkg::VAL_W-1:0] draw_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) return 8'h00;
		if (r < 20) return 8'hFF;
		return val_t'($urandom_range(0, 255));
	endfunction

	function automatic bsr_pkg::op_t draw_word(mix_t m, int fill);
		bsr_pkg::op_t w;
		int r;
		r = $urandom_range(0, 99);
		case (m)
			GROW: begin
				if (r < 65) w.kind = bsr_pkg::OP_PUSH;
				else if (r < 75) w.kind = bsr_pkg::OP_DUP;
				else if (r < 80) w.kind = bsr_pkg::OP_POP;
				else if (r < 85) w.kind = bsr_pkg::OP_PEEK;
				else if (r < 90) w.kind = bsr_pkg::OP_ROT_UP;
				else if (r < 95) w.kind = bsr_pkg::OP_ROT_DN;
				else w.kind = bsr_pkg::OP_PRINT;
			end
			SHRINK: begin
				if (r < 55) w.kind = bsr_pkg::OP_POP;
				else if (r < 65) w.kind = bsr_pkg::OP_PEEK;
				else if (r < 73) w.kind = bsr_pkg::OP_ROT_UP;
				else if (r < 81) w.kind = bsr_pkg::OP_ROT_DN;
				else if (r < 86) w.kind = bsr_pkg::OP_PRINT;
				else if (r < 96) w.kind = bsr_pkg::OP_PUSH;
				else w.kind = bsr_pkg::OP_DUP;
			end
			default: w.kind = bsr_pkg::op_kind_t'($urandom_range(0, 6));
		endcase
		w.value = draw_byte();
		if (fill > 0 && $urandom_range(0, 99) < 80) w.count = cnt_t'($urandom_range(1, fill));
		else w.count = cnt_t'($urandom_range(0, 64));
		return w;
	endfunction

	task automatic issue(bsr_pkg::op_kind_t k, logic [bsr_pkg::VAL_W-1:0] v,
		logic [bsr_pkg::CNT_W-1:0] n);
		bsr_pkg::op_t w;
		int gap;
		w.kind = k;
		w.value = v;
		w.count = n;
		req.valid <= 1'b1;
		req.cmd <= w.kind;
		req.value <= w.value;
		req.count <= w.count;
		do @(posedge clk); while (req.ready !== 1'b1);
		tracker.note_command(w);
		gap = snd_idle ? gap_len() : 0;
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic settle();
		req.valid <= 1'b0;
		while (tracker.pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(logic [bsr_pkg::CAP_W-1:0] c);
		cfg_we <= 1'b1;
		cfg_wdata <= c;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.set_capacity(c);
	endtask

	task automatic run_phase(logic [bsr_pkg::CAP_W-1:0] c, int items, int grow_n, bit s_idle,
		bit r_idle, bit hold);
		bsr_pkg::op_t w;
		mix_t m;
		int k;
		settle();
		write_capacity(c);
		snd_idle = s_idle;
		rcv_idle = r_idle;
		if (hold) hold_req = 1'b1;
		for (k = 0; k < items; k++) begin
			m = (k < grow_n) ? GROW : mix_t'(((k - grow_n) / 16) % 3);
			w = draw_word(m, tracker.fill);
			issue(w.kind, w.value, w.count);
		end
	endtask

	// result side: random back-pressure plus one long hold-off on request
	initial begin
		int stall;
		rsp_word_t got;
		stall = 0;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
				got.status = rsp.status;
				got.has_byte = rsp.has_byte;
				got.data_byte = rsp.data_byte;
				got.last = rsp.last;
				tracker.check_result(got);
			end
			if (hold_req) begin
				stall = HOLD_CYCLES;
				hold_req = 1'b0;
			end else if (stall == 0 && rcv_idle && $urandom_range(0, 99) < 30) begin
				stall = gap_len();
			end
			rsp.ready <= (stall == 0);
			if (stall > 0) stall--;
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !arst_n) quiet = 0;
			else quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		req.valid <= 1'b0;
		req.cmd <= '0;
		req.value <= '0;
		req.count <= '0;
		snd_idle = 1'b1;
		rcv_idle = 1'b1;
		hold_req = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corners on an empty and a full stack, with pushes and dups past capacity
		write_capacity(7'd3);
		issue(bsr_pkg::OP_POP, 8'h00, 7'd0);
		issue(bsr_pkg::OP_PEEK, 8'h00, 7'd0);
		issue(bsr_pkg::OP_PRINT, 8'h00, 7'd0);
		issue(bsr_pkg::OP_DUP, 8'h00, 7'd0);
		issue(bsr_pkg::OP_ROT_UP, 8'h00, 7'd0);
		issue(bsr_pkg::OP_ROT_DN, 8'h00, 7'd1);
		issue(bsr_pkg::OP_PUSH, 8'h00, 7'd0);
		issue(bsr_pkg::OP_PUSH, 8'hFF, 7'd0);
		issue(bsr_pkg::OP_DUP, 8'h00, 7'd0);
		issue(bsr_pkg::OP_PUSH, 8'hA5, 7'd0);
		issue(bsr_pkg::OP_DUP, 8'h00, 7'd0);
		issue(bsr_pkg::OP_ROT_UP, 8'h00, 7'd4);
		issue(bsr_pkg::OP_ROT_DN, 8'h00, 7'd1);
		issue(bsr_pkg::OP_ROT_UP, 8'h00, 7'd3);
		issue(bsr_pkg::OP_ROT_DN, 8'h00, 7'd3);
		issue(bsr_pkg::OP_ROT_DN, 8'h00, 7'd0);
		issue(bsr_pkg::OP_PRINT, 8'h00, 7'd0);
		issue(bsr_pkg::OP_PEEK, 8'h00, 7'd0);
		issue(bsr_pkg::OP_POP, 8'h00, 7'd0);
		settle();
		write_capacity(7'd1);
		issue(bsr_pkg::OP_PUSH, 8'h5A, 7'd0);
		issue(bsr_pkg::OP_DUP, 8'h00, 7'd0);
		issue(bsr_pkg::OP_POP, 8'h00, 7'd0);
		issue(bsr_pkg::OP_POP, 8'h00, 7'd0);
		settle();
		write_capacity(7'd64);
		issue(bsr_pkg::OP_ROT_UP, 8'h00, 7'd64);
		issue(bsr_pkg::OP_ROT_DN, 8'h00, 7'd64);

		run_phase(7'd64, 100, 90, 1'b1, 1'b1, 1'b1);
		run_phase(7'd64, 60, 0, 1'b0, 1'b0, 1'b0);
		run_phase(7'd1, 40, 4, 1'b1, 1'b1, 1'b0);
		run_phase(7'd17, 60, 20, 1'b1, 1'b0, 1'b0);
		run_phase(7'd63, 60, 40, 1'b0, 1'b1, 1'b0);
		run_phase(7'd2, 40, 4, 1'b1, 1'b1, 1'b0);
		run_phase(7'd40, 50, 30, 1'b1, 1'b1, 1'b0);
		settle();

		if (tracker.errors == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end

endmodule

// ===== byte_stack_with_rotate_core.f =====
rtl/bsr_pkg.sv
rtl/bsr_if.sv
rtl/bsr_front.sv
rtl/bsr_back.sv
rtl/byte_stack_with_rotate_core.sv
bench/byte_stack_with_rotate_core_tb.sv
